// ----- rtl/core/fde_pkg.sv -----
// shared types, constants and codes of the fat directory entry search
`timescale 1ns / 1ps

package fde_pkg;

	localparam int NAME_CHARS_DEF = 8;
	localparam int ENTRY_CHARS    = 8;
	localparam int CLUS_HALF_W    = 16;
	localparam int VALUE_W        = 32;

	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_END   = 8'h00;
	localparam logic [7:0] BYTE_FREE  = 8'hE5;
	localparam logic [7:0] ATTR_LFN   = 8'h0F;
	localparam logic [7:0] ATTR_DIR   = 8'h10;

	typedef enum logic [1:0] {
		ST_FOUND     = 2'd0,
		ST_END       = 2'd1,
		ST_NO_MARKER = 2'd2
	} status_t;

	typedef enum logic [0:0] {
		CFG_TARGET_NAME = 1'b0,
		CFG_SEARCH_MODE = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic                   start_scan;
		logic [8*ENTRY_CHARS-1:0] name_bytes;
		logic [7:0]             attribute;
		logic [CLUS_HALF_W-1:0] cluster_low;
		logic [CLUS_HALF_W-1:0] cluster_high;
		logic [VALUE_W-1:0]     size_bytes;
		logic                   last_in_cluster;
	} entry_t;

	typedef struct packed {
		status_t            status;
		logic [VALUE_W-1:0] value;
	} result_t;

	typedef struct packed {
		logic    fire;
		logic    done_next;
		result_t res;
	} decision_t;

endpackage

// ----- rtl/core/fde_if.sv -----
// item, result and configuration channel interfaces
`timescale 1ns / 1ps

interface fde_item_if;
	logic                                   valid;
	logic                                   ready;
	logic                                   start_scan;
	logic [8*fde_pkg::ENTRY_CHARS-1:0]      name_bytes;
	logic [7:0]                             attribute;
	logic [fde_pkg::CLUS_HALF_W-1:0]        cluster_low;
	logic [fde_pkg::CLUS_HALF_W-1:0]        cluster_high;
	logic [fde_pkg::VALUE_W-1:0]            size_bytes;
	logic                                   last_in_cluster;

	modport source (
		output valid, start_scan, name_bytes, attribute, cluster_low, cluster_high,
			size_bytes, last_in_cluster,
		input  ready
	);
	modport sink (
		input  valid, start_scan, name_bytes, attribute, cluster_low, cluster_high,
			size_bytes, last_in_cluster,
		output ready
	);
endinterface

interface fde_res_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  status;
	logic [fde_pkg::VALUE_W-1:0] value;

	modport source (output valid, status, value, input ready);
	modport sink (input valid, status, value, output ready);
endinterface

interface fde_cfg_if;
	logic        valid;
	logic        ready;
	logic [0:0]  index;
	logic [63:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/fde_match.sv -----
// entry classification, name compare and result selection
`timescale 1ns / 1ps

module fde_match #(
	parameter int NAME_CHARS = fde_pkg::NAME_CHARS_DEF
) (
	input  fde_pkg::entry_t                     entry,
	input  logic [8*fde_pkg::ENTRY_CHARS-1:0]   target_name,
	input  logic                                search_mode,
	input  logic                                scan_done,
	output fde_pkg::decision_t                  dec
);

	localparam int NCMP = (NAME_CHARS > fde_pkg::ENTRY_CHARS) ?
		fde_pkg::ENTRY_CHARS : NAME_CHARS;

	logic [7:0]                  first;
	logic [fde_pkg::VALUE_W-1:0] clus;
	logic                        is_end;
	logic                        skip;
	logic                        name_ok;
	logic                        hit;
	logic                        open;

	always_comb begin
		name_ok = 1'b1;
		for (int i = 0; i < fde_pkg::ENTRY_CHARS; i++) begin
			if (i < NCMP && entry.name_bytes[8*i +: 8] != fde_pkg::CHAR_SPACE &&
					entry.name_bytes[8*i +: 8] != target_name[8*i +: 8]) begin
				name_ok = 1'b0;
			end
		end
	end

	assign first  = entry.name_bytes[7:0];
	assign clus   = {entry.cluster_high, entry.cluster_low};
	assign is_end = (first == fde_pkg::CHAR_END);
	assign skip   = (first == fde_pkg::BYTE_FREE) || (entry.attribute == fde_pkg::ATTR_LFN) ||
		(search_mode ? (entry.attribute == fde_pkg::ATTR_DIR) : (clus == '0));
	assign hit    = !skip && name_ok;
	assign open   = entry.start_scan || !scan_done;

	always_comb begin
		dec.fire      = open && (is_end || hit || entry.last_in_cluster);
		dec.done_next = dec.fire || (scan_done && !entry.start_scan);
		dec.res.value = '0;
		priority if (is_end) begin
			dec.res.status = fde_pkg::ST_END;
		end else if (hit) begin
			dec.res.status = fde_pkg::ST_FOUND;
			dec.res.value  = search_mode ? entry.size_bytes : clus;
		end else begin
			dec.res.status = fde_pkg::ST_NO_MARKER;
		end
	end

endmodule

// ----- rtl/core/fat_directory_entry_search.sv -----
// top level of the fat directory entry search
`timescale 1ns / 1ps
// an accepted item is registered in entry_s1, and its result is registered in res_q
// throughput: one item per cycle, stalls only while the result register is held
// an item that gives no result still takes one pass through the result stage
// reset clears the entry and result valid flags, scan state and both config registers

module fat_directory_entry_search #(
	parameter int NAME_CHARS = fde_pkg::NAME_CHARS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	fde_item_if.sink       item,
	fde_res_if.source      res,
	fde_cfg_if.sink        cfg
);

	fde_pkg::entry_t                    entry_s1;
	logic                               valid_s1;
	fde_pkg::result_t                   res_q;
	logic                               res_valid_q;
	logic                               scan_done_q;
	logic [8*fde_pkg::ENTRY_CHARS-1:0]  target_name_q;
	logic                               search_mode_q;
	fde_pkg::decision_t                 dec;
	logic                               can_load;
	logic                               advance;

	assign can_load   = !res_valid_q || res.ready;
	assign advance    = valid_s1 && can_load;
	assign item.ready = !valid_s1 || can_load;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_name_q <= '0;
			search_mode_q <= 1'b0;
		end else if (cfg.valid) begin
			unique case (fde_pkg::cfg_idx_t'(cfg.index))
				fde_pkg::CFG_TARGET_NAME: target_name_q <= cfg.data;
				fde_pkg::CFG_SEARCH_MODE: search_mode_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			entry_s1.start_scan      <= item.start_scan;
			entry_s1.name_bytes      <= item.name_bytes;
			entry_s1.attribute       <= item.attribute;
			entry_s1.cluster_low     <= item.cluster_low;
			entry_s1.cluster_high    <= item.cluster_high;
			entry_s1.size_bytes      <= item.size_bytes;
			entry_s1.last_in_cluster <= item.last_in_cluster;
		end
	end

	fde_match #(
		.NAME_CHARS (NAME_CHARS)
	) u_match (
		.entry       (entry_s1),
		.target_name (target_name_q),
		.search_mode (search_mode_q),
		.scan_done   (scan_done_q),
		.dec         (dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_done_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (can_load) begin
			res_valid_q <= advance && dec.fire;
			if (advance) begin
				scan_done_q <= dec.done_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && dec.fire) begin
			res_q <= dec.res;
		end
	end

	assign res.valid  = res_valid_q;
	assign res.status = res_q.status;
	assign res.value  = res_q.value;

endmodule

// ----- rtl/core/fde_checker.sv -----
// port level checks of the fat directory entry search and their bind
`timescale 1ns / 1ps

module fde_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        res_valid,
	input logic                        res_ready,
	input logic [1:0]                  res_status,
	input logic [fde_pkg::VALUE_W-1:0] res_value
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result item dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_status) && $stable(res_value))
		else $error("stalled result item changed");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_status == fde_pkg::ST_FOUND || res_status == fde_pkg::ST_END ||
			res_status == fde_pkg::ST_NO_MARKER))
		else $error("undefined status code");

	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status != fde_pkg::ST_FOUND |-> res_value == '0)
		else $error("nonzero value on not found");

endmodule

bind fat_directory_entry_search fde_checker u_fde_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (res.valid),
	.res_ready  (res.ready),
	.res_status (res.status),
	.res_value  (res.value)
);
